// ===== rtl/core/wbps_pkg.sv =====
// Shared types and constants for the wildcard byte pattern scanner.
`timescale 1ns / 1ps

package wbps_pkg;

    // A pattern byte with this value matches any data byte.
    localparam logic [7:0] WILDCARD_BYTE = 8'h2A;

    // Number of pattern bytes the configuration registers can hold.
    localparam int PATTERN_REG_BYTES = 16;

    // Width of the pattern length register and of the effective length.
    localparam int LEN_W = 5;

    // Width of the configuration data and index.
    localparam int CFG_DATA_W = 64;
    localparam int CFG_INDEX_W = 3;

    // Width of the result address field.
    localparam int MATCH_ADDR_W = 48;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_PATTERN_LENGTH = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_START_ADDRESS  = 3'd3;

    // One input word: a byte of the scanned region and its end flag.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } wbps_in_t;

    // One result word.
    typedef struct packed {
        logic                    found;
        logic [MATCH_ADDR_W-1:0] match_address;
    } wbps_out_t;

    // Status handed from the cell row to the scan controller.
    typedef struct packed {
        logic advance;
        logic last_byte;
        logic window_hit;
    } wbps_scan_t;

endpackage

// ===== rtl/core/wbps_cell.sv =====
// One window cell: holds one byte of the scan window and compares its incoming byte.
`timescale 1ns / 1ps

module wbps_cell (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       advance,
    input  logic       clear,
    input  logic [7:0] byte_in,
    input  logic [7:0] pat_byte,
    output logic [7:0] byte_out,
    output logic       hit
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // The byte that enters this cell is the one the pattern is checked against.
    assign hit = (pat_byte == wbps_pkg::WILDCARD_BYTE) || (pat_byte == byte_in);

    // Shift the neighbor's byte in on every accepted word; the region end empties the cell.
    always_comb begin
        byte_next = byte_reg;
        if (advance) begin
            byte_next = clear ? 8'd0 : byte_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_reg <= 8'd0;
        end else begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

endmodule

// ===== rtl/core/wbps_ctrl.sv =====
// Scan controller: byte count, match bookkeeping and the two-entry result buffer.
`timescale 1ns / 1ps

module wbps_ctrl #(
    parameter int ADDRESS_BITS = 48
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  wbps_pkg::wbps_scan_t                 scan,
    input  logic [wbps_pkg::LEN_W-1:0]           eff_len,
    input  logic [wbps_pkg::MATCH_ADDR_W-1:0]    start_address,
    output logic                                 s_ready,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output wbps_pkg::wbps_out_t                  m_word
);

    logic [ADDRESS_BITS-1:0] bytes_seen_reg;
    logic [ADDRESS_BITS-1:0] bytes_seen_next;
    logic                    match_reported_reg;
    logic                    match_reported_next;

    logic                    m_valid_reg;
    logic                    m_valid_next;
    wbps_pkg::wbps_out_t     m_word_reg;
    wbps_pkg::wbps_out_t     m_word_next;
    logic                    skid_valid_reg;
    logic                    skid_valid_next;
    wbps_pkg::wbps_out_t     skid_word_reg;
    wbps_pkg::wbps_out_t     skid_word_next;

    logic [ADDRESS_BITS-1:0] seen_inc;
    logic [ADDRESS_BITS-1:0] match_addr;
    logic                    found_now;
    logic                    not_found_now;
    logic                    produce;
    logic                    take;
    wbps_pkg::wbps_out_t     new_word;

    // Count of bytes in the region including this one, held at the top value.
    assign seen_inc = (bytes_seen_reg == {ADDRESS_BITS{1'b1}}) ?
                      bytes_seen_reg : bytes_seen_reg + 1'b1;

    // Address of the first byte of a match that ends at this byte.
    assign match_addr = ADDRESS_BITS'(start_address) + seen_inc - ADDRESS_BITS'(eff_len);

    // A match counts only once the whole pattern lies inside the region.
    assign found_now = !match_reported_reg && (seen_inc >= ADDRESS_BITS'(eff_len)) &&
                       scan.window_hit;
    assign not_found_now = !match_reported_reg && scan.last_byte && !found_now;
    assign produce = scan.advance && (found_now || not_found_now);

    always_comb begin
        new_word.found = found_now;
        new_word.match_address = found_now ? wbps_pkg::MATCH_ADDR_W'(match_addr) : '0;
    end

    // Scan state follows each accepted word; the region end clears it.
    always_comb begin
        bytes_seen_next = bytes_seen_reg;
        match_reported_next = match_reported_reg;
        if (scan.advance) begin
            if (scan.last_byte) begin
                bytes_seen_next = '0;
                match_reported_next = 1'b0;
            end else begin
                bytes_seen_next = seen_inc;
                match_reported_next = match_reported_reg || found_now;
            end
        end
    end

    // Output register with a skid entry behind it, so input keeps flowing while a result waits.
    assign take = m_valid_reg && m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next = m_word_reg;
        skid_valid_next = skid_valid_reg;
        skid_word_next = skid_word_reg;
        if (m_valid_reg && !take) begin
            if (produce) begin
                skid_valid_next = 1'b1;
                skid_word_next = new_word;
            end
        end else if (skid_valid_reg) begin
            m_valid_next = 1'b1;
            m_word_next = skid_word_reg;
            skid_valid_next = 1'b0;
        end else if (produce) begin
            m_valid_next = 1'b1;
            m_word_next = new_word;
        end else begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_seen_reg <= '0;
            match_reported_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            bytes_seen_reg <= bytes_seen_next;
            match_reported_reg <= match_reported_next;
            m_valid_reg <= m_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
        skid_word_reg <= skid_word_next;
    end

    assign s_ready = !skid_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_word = m_word_reg;

`ifndef SYNTHESIS
    // The skid entry is only ever filled behind a held output word.
    a_skid_behind_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid entry valid while output register is empty");

    // A match inside a region blocks further results until the region ends.
    a_match_marks_region: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan.advance && found_now && !scan.last_byte) |=> match_reported_reg)
        else $error("match not recorded for the rest of the region");

    // The region end leaves a clean scan state.
    a_last_clears_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        (scan.advance && scan.last_byte) |=> (bytes_seen_reg == '0 && !match_reported_reg))
        else $error("scan state not cleared after the last byte");

    // A not-found result carries a zero address.
    a_not_found_zero_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_word_reg.found) |-> (m_word_reg.match_address == '0))
        else $error("not-found result with a nonzero address");
`endif

endmodule

// ===== rtl/core/wildcard_byte_pattern_scan.sv =====
// Top level of the wildcard byte pattern scanner: configuration, cell row and controller.
`timescale 1ns / 1ps

// Usage:
// The input channel (s_valid, s_ready, s_word) carries one byte of a memory region per
// word, with last_byte set on the final byte. The result channel (m_valid, m_ready,
// m_word) carries at most one word per region: found = 1 with the address of the first
// byte of the earliest match, or found = 0 at the last byte if nothing matched.
// A pattern byte of 0x2A matches any data byte. Configuration is written through
// cfg_we, cfg_index and cfg_wdata while no word is in flight.
// Throughput is one byte per cycle while s_ready is high: each byte shifts through
// the row of window cells, every cell compares in parallel and the controller forms
// the address in the same cycle, so nothing iterates. A result word is registered in
// the output register; if the receiver stalls, one further result can park in a skid
// entry. s_ready drops only while that entry is full.
// Reset clears the window, the byte count, the match flag and the result buffer, and
// returns the registers to an all-zero pattern of length one at start address zero.

module wildcard_byte_pattern_scan #(
    parameter int PATTERN_MAX  = 16,
    parameter int ADDRESS_BITS = 48
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [wbps_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  wbps_pkg::wbps_in_t                   s_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output wbps_pkg::wbps_out_t                  m_word
);

    // Cells that can take part in a compare.
    localparam int CMP_CELLS = (PATTERN_MAX < wbps_pkg::PATTERN_REG_BYTES) ?
                               PATTERN_MAX : wbps_pkg::PATTERN_REG_BYTES;

    logic [63:0]                           pattern_low_reg;
    logic [63:0]                           pattern_high_reg;
    logic [wbps_pkg::LEN_W-1:0]            pattern_length_reg;
    logic [wbps_pkg::MATCH_ADDR_W-1:0]     start_address_reg;

    logic [wbps_pkg::LEN_W-1:0]            eff_len;
    logic [127:0]                          pattern_all;
    logic                                  advance;
    logic                                  clear;
    logic [7:0]                            cell_bytes [PATTERN_MAX];
    logic [7:0]                            cell_pat [PATTERN_MAX];
    logic [PATTERN_MAX-1:0]                cell_hit;
    logic [PATTERN_MAX-1:0]                cell_use;
    wbps_pkg::wbps_scan_t                  scan;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg <= '0;
            pattern_high_reg <= '0;
            pattern_length_reg <= wbps_pkg::LEN_W'(1);
            start_address_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                wbps_pkg::CFG_PATTERN_LOW: begin
                    pattern_low_reg <= cfg_wdata;
                end
                wbps_pkg::CFG_PATTERN_HIGH: begin
                    pattern_high_reg <= cfg_wdata;
                end
                wbps_pkg::CFG_PATTERN_LENGTH: begin
                    pattern_length_reg <= cfg_wdata[wbps_pkg::LEN_W-1:0];
                end
                wbps_pkg::CFG_START_ADDRESS: begin
                    start_address_reg <= cfg_wdata[wbps_pkg::MATCH_ADDR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // Length in use: zero counts as one, and it is capped by the pattern and window sizes.
    always_comb begin
        eff_len = pattern_length_reg;
        if (eff_len == '0) begin
            eff_len = wbps_pkg::LEN_W'(1);
        end
        if (eff_len > wbps_pkg::LEN_W'(CMP_CELLS)) begin
            eff_len = wbps_pkg::LEN_W'(CMP_CELLS);
        end
    end

    assign pattern_all = {pattern_high_reg, pattern_low_reg};
    assign advance = s_valid && s_ready;
    assign clear = advance && s_word.last_byte;

    // Row of window cells; cell j holds the byte j places back from the newest one.
    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        logic [7:0] byte_in;

        if (j == 0) begin : g_head
            assign byte_in = s_word.data_byte;
        end else begin : g_body
            assign byte_in = cell_bytes[j-1];
        end

        // Cell j lines up with pattern byte length-1-j.
        if (j < CMP_CELLS) begin : g_cmp
            logic [wbps_pkg::LEN_W-1:0] pat_idx;
            assign pat_idx = eff_len - wbps_pkg::LEN_W'(j) - wbps_pkg::LEN_W'(1);
            assign cell_pat[j] = pattern_all[{pat_idx[3:0], 3'b000} +: 8];
            assign cell_use[j] = wbps_pkg::LEN_W'(j) < eff_len;
        end else begin : g_nocmp
            assign cell_pat[j] = 8'd0;
            assign cell_use[j] = 1'b0;
        end

        wbps_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .clear    (clear),
            .byte_in  (byte_in),
            .pat_byte (cell_pat[j]),
            .byte_out (cell_bytes[j]),
            .hit      (cell_hit[j])
        );
    end

    // The window matches when every cell in use agrees with its pattern byte.
    always_comb begin
        scan.advance = advance;
        scan.last_byte = s_word.last_byte;
        scan.window_hit = &(cell_hit | ~cell_use);
    end

    wbps_ctrl #(
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .scan          (scan),
        .eff_len       (eff_len),
        .start_address (start_address_reg),
        .s_ready       (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_word        (m_word)
    );

endmodule

// ===== tb/sv/tb_top.sv =====
// Testbench for the wildcard byte pattern scanner: directed and random regions with a predictor.
`timescale 1ns / 1ps

module tb_top;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_WORDS = 1750;
    localparam int REPORT_MAX   = 10;
    localparam int TAIL_CYCLES  = 4;
    localparam int WINDOW_DEPTH = 16;

    // An index that no register decodes; a write to it must change nothing.
    localparam logic [wbps_pkg::CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             cfg_we    = 1'b0;
    logic [wbps_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [wbps_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    wbps_pkg::wbps_in_t               s_word    = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    wbps_pkg::wbps_out_t              m_word;

    // Register copies as the block should hold them.
    logic [63:0]                       pat_lo_q    = '0;
    logic [63:0]                       pat_hi_q    = '0;
    logic [wbps_pkg::LEN_W-1:0]        pat_len_q   = 5'd1;
    logic [wbps_pkg::MATCH_ADDR_W-1:0] base_addr_q = '0;

    // Scan state of the predictor.
    logic [7:0]                        win_q [WINDOW_DEPTH];
    logic [wbps_pkg::MATCH_ADDR_W-1:0] seen_q      = '0;
    bit                                reported_q  = 1'b0;

    wbps_pkg::wbps_out_t scan_results_q [$];
    logic [7:0]          region_q [$];

    int  words_sent  = 0;
    int  fail_cnt    = 0;
    int  cycle_cnt   = 0;
    int  stall_left  = 0;
    bit  send_gaps   = 1'b1;
    bit  recv_stalls = 1'b1;

    wildcard_byte_pattern_scan DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_word    (s_word),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Pattern length in use: zero counts as one, anything past sixteen saturates.
    function automatic int scan_len();
        if (pat_len_q == 0)
            return 1;
        if (pat_len_q > wbps_pkg::LEN_W'(wbps_pkg::PATTERN_REG_BYTES))
            return wbps_pkg::PATTERN_REG_BYTES;
        return int'(pat_len_q);
    endfunction

    function automatic logic [7:0] pat_byte(input int k);
        return (k < 8) ? pat_lo_q[8*k +: 8] : pat_hi_q[8*(k-8) +: 8];
    endfunction

    // Shifts one byte into the window and works out the result it causes, if any.
    function automatic bit scan_byte(input wbps_pkg::wbps_in_t w,
                                     output wbps_pkg::wbps_out_t r);
        int         len;
        int         i;
        int         k;
        bit         hit;
        logic [7:0] p;
        len = scan_len();
        for (i = WINDOW_DEPTH - 1; i > 0; i--)
            win_q[i] = win_q[i-1];
        win_q[0] = w.data_byte;
        if (seen_q != '1)
            seen_q = seen_q + 1'b1;
        r = '0;
        scan_byte = 1'b0;
        hit = !reported_q && (seen_q >= wbps_pkg::MATCH_ADDR_W'(len));
        for (k = 0; k < len; k++) begin
            p = pat_byte(k);
            if (p != wbps_pkg::WILDCARD_BYTE && p != win_q[len-1-k])
                hit = 1'b0;
        end
        if (hit) begin
            r.found = 1'b1;
            r.match_address = base_addr_q + seen_q - wbps_pkg::MATCH_ADDR_W'(len);
            reported_q = 1'b1;
            scan_byte = 1'b1;
        end else if (!reported_q && w.last_byte) begin
            scan_byte = 1'b1;
        end
        if (w.last_byte) begin
            for (i = 0; i < WINDOW_DEPTH; i++)
                win_q[i] = '0;
            seen_q = '0;
            reported_q = 1'b0;
        end
    endfunction

    // Predicts on every accepted input word and checks every accepted result word.
    always @(posedge aclk) begin
        wbps_pkg::wbps_out_t r;
        wbps_pkg::wbps_out_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                if (scan_byte(s_word, r))
                    scan_results_q.push_back(r);
            end
            if (m_valid && m_ready) begin
                if (scan_results_q.size() == 0) begin
                    fail_cnt++;
                    if (fail_cnt <= REPORT_MAX)
                        $display("Unexpected result word: found=%0b addr=%h",
                                 m_word.found, m_word.match_address);
                end else begin
                    want = scan_results_q.pop_front();
                    if (want.found !== m_word.found ||
                        want.match_address !== m_word.match_address) begin
                        fail_cnt++;
                        if (fail_cnt <= REPORT_MAX)
                            $display("Mismatch: expected found=%0b addr=%h, got found=%0b addr=%h",
                                     want.found, want.match_address,
                                     m_word.found, m_word.match_address);
                    end
                end
            end
        end
    end

    // Receiver: after each result word, may hold ready low for a random stall while recv_stalls is set.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else if (m_valid && m_ready) begin
            stall_left = recv_stalls ? $urandom_range(0, 14) : 0;
            m_ready <= (stall_left == 0);
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= (stall_left == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Guard against a hung handshake.
    always @(posedge aclk) begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Sends one word after a random gap and returns at the edge that accepts it.
    task automatic send_word(input logic [7:0] b, input logic last);
        int gap;
        gap = send_gaps ? $urandom_range(0, 14) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= '{data_byte: b, last_byte: last};
        do @(posedge aclk); while (!(s_valid && s_ready));
        words_sent++;
    endtask

    task automatic send_region_part(input int first, input int stop);
        int i;
        for (i = first; i < stop; i++)
            send_word(region_q[i], i == region_q.size() - 1);
    endtask

    task automatic send_region();
        send_region_part(0, region_q.size());
    endtask

    // Stops sending and waits until every expected result word has come back.
    task automatic wait_scan_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (scan_results_q.size() != 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
    endtask

    // Drives one register write and keeps the copy in step with it.
    task automatic write_reg(input logic [wbps_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [63:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            wbps_pkg::CFG_PATTERN_LOW:    pat_lo_q = val;
            wbps_pkg::CFG_PATTERN_HIGH:   pat_hi_q = val;
            wbps_pkg::CFG_PATTERN_LENGTH: pat_len_q = val[wbps_pkg::LEN_W-1:0];
            wbps_pkg::CFG_START_ADDRESS:  base_addr_q = val[wbps_pkg::MATCH_ADDR_W-1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    // Writes all four registers once the block is idle; unused upper bits get junk at times.
    task automatic set_scan_config(input logic [63:0] lo, input logic [63:0] hi,
                                   input logic [wbps_pkg::LEN_W-1:0] len_raw,
                                   input logic [wbps_pkg::MATCH_ADDR_W-1:0] start);
        logic [63:0] v;
        wait_scan_idle();
        write_reg(wbps_pkg::CFG_PATTERN_LOW, lo);
        write_reg(wbps_pkg::CFG_PATTERN_HIGH, hi);
        v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
        v[wbps_pkg::LEN_W-1:0] = len_raw;
        write_reg(wbps_pkg::CFG_PATTERN_LENGTH, v);
        v = ($urandom_range(0, 3) == 0) ? {$urandom, $urandom} : 64'd0;
        v[wbps_pkg::MATCH_ADDR_W-1:0] = start;
        write_reg(wbps_pkg::CFG_START_ADDRESS, v);
        cfg_we <= 1'b0;
    endtask

    task automatic set_random_config();
        logic [63:0]                       lo;
        logic [63:0]                       hi;
        logic [wbps_pkg::LEN_W-1:0]        len_raw;
        logic [wbps_pkg::MATCH_ADDR_W-1:0] start;
        int                                k;
        for (k = 0; k < 8; k++) begin
            lo[8*k +: 8] = ($urandom_range(0, 4) == 0) ? wbps_pkg::WILDCARD_BYTE
                                                       : 8'($urandom_range(0, 255));
            hi[8*k +: 8] = ($urandom_range(0, 4) == 0) ? wbps_pkg::WILDCARD_BYTE
                                                       : 8'($urandom_range(0, 255));
        end
        len_raw = ($urandom_range(0, 9) == 0) ? wbps_pkg::LEN_W'($urandom_range(0, 31))
                                              : wbps_pkg::LEN_W'($urandom_range(1, 16));
        case ($urandom_range(0, 5))
            0: start = '0;
            1: start = 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 40));
            default: start = 48'({$urandom, $urandom});
        endcase
        set_scan_config(lo, hi, len_raw, start);
    endtask

    // A byte that the current pattern accepts at position k.
    function automatic logic [7:0] planted_byte(input int k);
        logic [7:0] b;
        b = pat_byte(k);
        return (b == wbps_pkg::WILDCARD_BYTE) ? 8'($urandom_range(0, 255)) : b;
    endfunction

    // Filler byte; the narrow alphabet makes chance matches and near misses likely.
    function automatic logic [7:0] noise_byte(input bit narrow);
        if (!narrow)
            return 8'($urandom_range(0, 255));
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            2: return wbps_pkg::WILDCARD_BYTE;
            default: return pat_byte(0);
        endcase
    endfunction

    // Registers at their reset values: a single zero byte pattern at address zero.
    task automatic test_reset_values();
        region_q = {8'h5A, 8'h00, 8'hFF};
        send_region();
        region_q = {8'hFF};
        send_region();
    endtask

    // Wildcard in the middle, match on the last byte, a short region, bytes after a match,
    // and an address sum that wraps past the top.
    task automatic test_wildcard_match();
        set_scan_config(64'hFFFF_FFFF_EF2A_ADDE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd4,
                        48'hFFFF_FFFF_FFFE);
        region_q = {8'hDE, 8'hAD, 8'h00, 8'hEF};
        send_region();
        region_q = {8'hDE, 8'hAD};
        send_region();
        region_q = {8'h2A, 8'hDE, 8'hAD, 8'hFF, 8'hEF, 8'hDE, 8'hAD, 8'h2A, 8'hEF};
        send_region();
    endtask

    // A length past sixteen saturates to sixteen, and a length of zero acts as one.
    task automatic test_length_limits();
        int k;
        set_scan_config(64'h2A2A_2A2A_2A2A_2A2A, 64'hFF2A_2A2A_2A2A_2A2A, 5'd31,
                        48'h0000_0000_1234);
        region_q.delete();
        for (k = 0; k < 15; k++)
            region_q.push_back((k == 0) ? 8'h00 : 8'($urandom_range(0, 255)));
        region_q.push_back(8'hFF);
        send_region();
        set_scan_config(64'h0000_0000_0000_002A, 64'hFF2A_2A2A_2A2A_2A2A, 5'd0, 48'h0);
        region_q = {8'h00};
        send_region();
    endtask

    // A register change in the middle of a region keeps the window contents.
    task automatic test_config_mid_region();
        set_scan_config(64'h0000_0000_0000_CDAB, 64'h0, 5'd2, 48'h0000_0000_0100);
        send_word(8'hAB, 1'b0);
        wait_scan_idle();
        write_reg(CFG_UNUSED_INDEX, {$urandom, $urandom});
        cfg_we <= 1'b0;
        set_scan_config(64'h0000_0000_0000_2AAB, 64'h0, 5'd2, 48'h0000_0000_0100);
        send_word(8'h55, 1'b0);
        send_word(8'h00, 1'b1);
    endtask

    // Random regions: half planted matches, some near misses, noise and one-byte bursts.
    task automatic test_random_regions();
        int stop_at;
        int region_cnt;
        int mode;
        int eff;
        int pre;
        int post;
        int cut;
        int k;
        bit narrow;
        stop_at = words_sent + RANDOM_WORDS;
        region_cnt = 0;
        while (words_sent < stop_at) begin
            if (region_cnt % 8 == 0)
                set_random_config();
            else if (region_cnt % 25 == 0)
                wait_scan_idle();
            send_gaps   = ($urandom_range(0, 3) != 0);
            recv_stalls = ($urandom_range(0, 3) != 0);
            eff    = scan_len();
            narrow = ($urandom_range(0, 3) == 0);
            mode   = $urandom_range(0, 11);
            region_q.delete();
            if (mode >= 10) begin
                region_q.push_back(noise_byte(narrow));
            end else begin
                pre  = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 120)
                                                    : $urandom_range(0, 12);
                post = $urandom_range(0, 6);
                for (k = 0; k < pre; k++)
                    region_q.push_back(noise_byte(narrow));
                if (mode <= 5) begin
                    for (k = 0; k < eff; k++)
                        region_q.push_back(planted_byte(k));
                end else if (mode <= 7) begin
                    cut = $urandom_range(0, eff - 1);
                    for (k = 0; k < cut; k++)
                        region_q.push_back(planted_byte(k));
                    region_q.push_back(~pat_byte(cut));
                end
                for (k = 0; k < post; k++)
                    region_q.push_back(noise_byte(narrow));
                if (region_q.size() == 0)
                    region_q.push_back(noise_byte(narrow));
            end
            if ($urandom_range(0, 11) == 0 && region_q.size() > 1) begin
                cut = $urandom_range(1, region_q.size() - 1);
                send_region_part(0, cut);
                set_random_config();
                send_region_part(cut, region_q.size());
            end else begin
                send_region();
            end
            region_cnt++;
        end
    endtask

    initial begin
        for (int i = 0; i < WINDOW_DEPTH; i++)
            win_q[i] = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_wildcard_match();
        test_length_limits();
        test_config_mid_region();
        test_random_regions();
        wait_scan_idle();
        repeat (8) @(posedge aclk);
        if (fail_cnt == 0 && scan_results_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
